[rtl/ctcg_pkg.sv]
// shared types, widths and constants of the ctc greedy decoder
package ctcg_pkg;

	localparam int VOCAB_MAX_DEF  = 4096;
	localparam int LOGIT_BITS_DEF = 16;

	localparam int VOCAB_W = 13;
	localparam int BLANK_W = 12;
	localparam int ID_W    = 12;
	localparam int PROB_W  = 16;
	localparam int COUNT_W = 16;
	localparam int SUM_W   = 32;
	localparam int MB_W    = 17;
	localparam int DIV_W   = 33;

	localparam int VOCAB_RESET = 4096;
	localparam int BLANK_RESET = 4095;

	localparam int EXP_LOG2E = 94548;
	localparam int EXP_LIN   = 44012;
	localparam int EXP_QUAD  = 11244;
	localparam int ONE_Q16   = 65536;
	localparam int CONF_MAX  = 65535;
	localparam int COUNT_MAX = 65535;
	localparam int K_LIMIT   = 16;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = VOCAB_W;

	localparam logic [CFG_IDX_W-1:0] REG_VOCAB_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_INDEX = 1'b1;

	localparam logic KIND_TOKEN   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[rtl/ctcg_mul.sv]
// shared multiplier with registered product
module ctcg_mul #(
	parameter int A_W = 32,
	parameter int B_W = 17
) (
	input  logic               clk,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic [A_W+B_W-1:0] p
);

	logic [A_W+B_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
	end

	assign p = p_q;

endmodule

[rtl/ctcg_div.sv]
// restoring divider, one quotient bit per cycle
module ctcg_div #(
	parameter int DW = ctcg_pkg::DIV_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DW-1:0]         dividend,
	input  logic [DW-1:0]         divisor,
	output logic [DW-1:0]         quotient,
	output ctcg_pkg::div_stat_t   stat
);

	import ctcg_pkg::*;

	localparam int CNT_W = (DW > 2) ? $clog2(DW) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [DW-1:0]    den_q;
	logic [DW:0]      rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DW'(rem_sh - {1'b0, den_q});
			end else begin
				rem_q <= rem_sh[DW-1:0];
			end
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[rtl/ctc_greedy_decoder.sv]
// ctc greedy decoder top level: frame argmax, softmax confidence, token collapsing
// the first logit of a frame only sets the maximum; each later one takes the exp path, plus a rescale on a new maximum;
// the exp term goes through five passes of the one shared multiplier
// closing a frame adds a reciprocal on the bit-serial divider,
// end of utterance a division for the mean when tokens were counted, plus any wait on the output word
// reset: vocab_size 4096, blank_index 4095, frame and utterance state cleared
module ctc_greedy_decoder #(
	parameter int VOCAB_MAX  = ctcg_pkg::VOCAB_MAX_DEF,
	parameter int LOGIT_BITS = ctcg_pkg::LOGIT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ctcg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ctcg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [LOGIT_BITS-1:0]     logit,
	input  logic                             end_of_utterance,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             kind,
	output logic [ctcg_pkg::ID_W-1:0]        token_id,
	output logic [ctcg_pkg::PROB_W-1:0]      token_confidence,
	output logic [ctcg_pkg::PROB_W-1:0]      mean_confidence,
	output logic [ctcg_pkg::COUNT_W-1:0]     tok_total,
	output logic                             last
);

	import ctcg_pkg::*;

	localparam int IDX_W  = $clog2(VOCAB_MAX);
	localparam int CMP_W  = (IDX_W > VOCAB_W) ? IDX_W : VOCAB_W;
	localparam int VCLAMP = (VOCAB_MAX > (2**VOCAB_W - 1)) ? (2**VOCAB_W - 1) : VOCAB_MAX;
	localparam int D_W    = LOGIT_BITS + 1;
	localparam int MA_W   = (D_W > SUM_W) ? D_W : SUM_W;
	localparam int P_W    = MA_W + MB_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL_T,
		ST_T,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_ACC,
		ST_SCALE,
		ST_CHECK,
		ST_CONF_WAIT,
		ST_DECIDE,
		ST_EMIT_TOK,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_EMIT_SUM
	} state_t;

	state_t state_q;

	logic [VOCAB_W-1:0] vocab_q;
	logic [BLANK_W-1:0] blank_q;

	logic signed [LOGIT_BITS-1:0] x_q;
	logic                         eou_q;
	logic [IDX_W-1:0]             idx_q;
	logic signed [LOGIT_BITS-1:0] max_q;
	logic [IDX_W-1:0]             argmax_q;
	logic [SUM_W-1:0]             exp_sum_q;
	logic [IDX_W-1:0]             prev_q;
	logic                         prev_valid_q;
	logic [SUM_W-1:0]             conf_sum_q;
	logic [COUNT_W-1:0]           count_q;
	logic                         gt_q;
	logic [D_W-1:0]               d_q;
	logic [7:0]                   f_q;
	logic [4:0]                   k_q;
	logic                         kbig_q;
	logic [PROB_W-1:0]            lin_q;
	logic [MB_W-1:0]              e_q;
	logic [PROB_W-1:0]            conf_q;
	logic [PROB_W-1:0]            mean_q;

	logic               out_valid_q;
	logic               kind_q;
	logic [ID_W-1:0]    token_id_q;
	logic [PROB_W-1:0]  token_conf_q;
	logic [PROB_W-1:0]  mean_conf_q;
	logic [COUNT_W-1:0] tok_total_q;
	logic               last_q;

	logic [VOCAB_W-1:0] vocab_eff;
	logic [VOCAB_W-1:0] vocab_m1;
	logic [VOCAB_W-1:0] blank_eff;
	logic               at_end;
	logic               closing;
	logic               is_blank;
	logic               is_repeat;
	logic               out_free;
	logic               emit_go;

	logic signed [D_W-1:0] xe;
	logic signed [D_W-1:0] me;
	logic                  gt;
	logic [D_W-1:0]        diff;
	logic [MB_W-1:0]       m_val;

	logic [MA_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	logic [P_W-1:0]  prod;

	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [DIV_W-1:0] div_divisor;
	logic [DIV_W-1:0] div_quo;
	div_stat_t        div_stat;

	// effective vocabulary and blank
	always_comb begin
		if (vocab_q < VOCAB_W'(2)) begin
			vocab_eff = VOCAB_W'(2);
		end else if (vocab_q > VOCAB_W'(VCLAMP)) begin
			vocab_eff = VOCAB_W'(VCLAMP);
		end else begin
			vocab_eff = vocab_q;
		end
		vocab_m1 = vocab_eff - 1'b1;
		if ({1'b0, blank_q} >= vocab_eff) begin
			blank_eff = vocab_m1;
		end else begin
			blank_eff = {1'b0, blank_q};
		end
	end

	assign at_end    = CMP_W'(idx_q) >= CMP_W'(vocab_m1);
	assign closing   = eou_q || at_end;
	assign is_blank  = CMP_W'(argmax_q) == CMP_W'(blank_eff);
	assign is_repeat = prev_valid_q && (prev_q == argmax_q);
	assign out_free  = !out_valid_q || out_ready;
	assign emit_go   = ((state_q == ST_EMIT_TOK) || (state_q == ST_EMIT_SUM)) && out_free;

	assign xe   = D_W'(x_q);
	assign me   = D_W'(max_q);
	assign gt   = x_q > max_q;
	assign diff = gt ? D_W'(xe - me) : D_W'(me - xe);

	// exp mantissa from the linear and square terms
	assign m_val = MB_W'(ONE_Q16) - MB_W'(lin_q) + MB_W'(prod[29:16]);

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_T: begin
				mul_a = MA_W'(d_q);
				mul_b = MB_W'(EXP_LOG2E);
			end
			ST_T: begin
				mul_a = MA_W'(prod[23:16]);
				mul_b = MB_W'(EXP_LIN);
			end
			ST_F1: begin
				mul_a = MA_W'(f_q);
				mul_b = MB_W'(f_q);
			end
			ST_F2: begin
				mul_a = MA_W'(prod[15:0]);
				mul_b = MB_W'(EXP_QUAD);
			end
			ST_ACC: begin
				mul_a = MA_W'(exp_sum_q);
				mul_b = e_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ctcg_mul #(
		.A_W(MA_W),
		.B_W(MB_W)
	) u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p  (prod)
	);

	// divider requests: reciprocal at frame close, mean at end of utterance
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		if (state_q == ST_CHECK) begin
			div_start    = closing;
			div_dividend = DIV_W'(64'h1_0000_0000);
			div_divisor  = DIV_W'(exp_sum_q);
		end else if (state_q == ST_MEAN_GO) begin
			div_start    = count_q != '0;
			div_dividend = DIV_W'(conf_sum_q);
			div_divisor  = DIV_W'(count_q);
		end
	end

	ctcg_div #(
		.DW(DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.quotient(div_quo),
		.stat    (div_stat)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_q <= VOCAB_W'(VOCAB_RESET);
			blank_q <= BLANK_W'(BLANK_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VOCAB_SIZE:  vocab_q <= cfg_data;
				REG_BLANK_INDEX: blank_q <= cfg_data[BLANK_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			x_q           <= '0;
			eou_q         <= 1'b0;
			idx_q         <= '0;
			max_q         <= '0;
			argmax_q      <= '0;
			exp_sum_q     <= '0;
			prev_q        <= '0;
			prev_valid_q  <= 1'b0;
			conf_sum_q    <= '0;
			count_q       <= '0;
			gt_q          <= 1'b0;
			d_q           <= '0;
			f_q           <= '0;
			k_q           <= '0;
			kbig_q        <= 1'b0;
			lin_q         <= '0;
			e_q           <= '0;
			conf_q        <= '0;
			mean_q        <= '0;
			out_valid_q   <= 1'b0;
			kind_q        <= KIND_TOKEN;
			token_id_q    <= '0;
			token_conf_q  <= '0;
			mean_conf_q   <= '0;
			tok_total_q   <= '0;
			last_q        <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						x_q     <= logit;
						eou_q   <= end_of_utterance;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					if (idx_q == '0) begin
						max_q     <= x_q;
						argmax_q  <= '0;
						exp_sum_q <= SUM_W'(ONE_Q16);
						state_q   <= ST_CHECK;
					end else begin
						gt_q    <= gt;
						d_q     <= diff;
						state_q <= ST_MUL_T;
					end
				end
				ST_MUL_T: begin
					state_q <= ST_T;
				end
				ST_T: begin
					f_q     <= prod[23:16];
					k_q     <= prod[28:24];
					kbig_q  <= prod[P_W-1:24] > (P_W-24)'(K_LIMIT);
					state_q <= ST_F1;
				end
				ST_F1: begin
					lin_q   <= prod[23:8];
					state_q <= ST_F2;
				end
				ST_F2: begin
					state_q <= ST_F3;
				end
				ST_F3: begin
					e_q     <= kbig_q ? '0 : (m_val >> k_q);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (gt_q) begin
						state_q <= ST_SCALE;
					end else begin
						exp_sum_q <= exp_sum_q + SUM_W'(e_q);
						state_q   <= ST_CHECK;
					end
				end
				ST_SCALE: begin
					exp_sum_q <= SUM_W'(prod >> 16) + SUM_W'(ONE_Q16);
					max_q     <= x_q;
					argmax_q  <= idx_q;
					state_q   <= ST_CHECK;
				end
				ST_CHECK: begin
					if (closing) begin
						idx_q   <= '0;
						state_q <= ST_CONF_WAIT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_CONF_WAIT: begin
					if (div_stat.done) begin
						conf_q  <= (div_quo > DIV_W'(CONF_MAX)) ? PROB_W'(CONF_MAX)
							: div_quo[PROB_W-1:0];
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (is_blank) begin
						prev_valid_q <= 1'b0;
						state_q      <= eou_q ? ST_MEAN_GO : ST_IDLE;
					end else if (!is_repeat) begin
						prev_q       <= argmax_q;
						prev_valid_q <= 1'b1;
						if (count_q < COUNT_W'(COUNT_MAX)) begin
							conf_sum_q <= conf_sum_q + SUM_W'(conf_q);
							count_q    <= count_q + 1'b1;
						end
						state_q <= ST_EMIT_TOK;
					end else begin
						state_q <= eou_q ? ST_MEAN_GO : ST_IDLE;
					end
				end
				ST_EMIT_TOK: begin
					if (out_free) begin
						kind_q        <= KIND_TOKEN;
						token_id_q    <= ID_W'(argmax_q);
						token_conf_q  <= conf_q;
						mean_conf_q   <= '0;
						tok_total_q   <= '0;
						last_q        <= 1'b0;
						state_q       <= eou_q ? ST_MEAN_GO : ST_IDLE;
					end
				end
				ST_MEAN_GO: begin
					if (count_q == '0) begin
						mean_q  <= '0;
						state_q <= ST_EMIT_SUM;
					end else begin
						state_q <= ST_MEAN_WAIT;
					end
				end
				ST_MEAN_WAIT: begin
					if (div_stat.done) begin
						mean_q  <= div_quo[PROB_W-1:0];
						state_q <= ST_EMIT_SUM;
					end
				end
				ST_EMIT_SUM: begin
					if (out_free) begin
						kind_q        <= KIND_SUMMARY;
						token_id_q    <= '0;
						token_conf_q  <= '0;
						mean_conf_q   <= mean_q;
						tok_total_q   <= count_q;
						last_q        <= 1'b1;
						// utterance state back to reset values
						idx_q         <= '0;
						max_q         <= '0;
						argmax_q      <= '0;
						exp_sum_q     <= '0;
						prev_q        <= '0;
						prev_valid_q  <= 1'b0;
						conf_sum_q    <= '0;
						count_q       <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready        = 1'b1;
	assign in_ready         = state_q == ST_IDLE;
	assign out_valid        = out_valid_q;
	assign kind             = kind_q;
	assign token_id         = token_id_q;
	assign token_confidence = token_conf_q;
	assign mean_confidence  = mean_conf_q;
	assign tok_total        = tok_total_q;
	assign last             = last_q;

endmodule
